@@ hdl/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the log-barrier contact kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbc_pkg;

	typedef logic [19:0]        vid_t;
	typedef logic [31:0]        uq824_t;
	typedef logic signed [31:0] q824_t;
	typedef logic [31:0]        uq1616_t;
	typedef logic signed [63:0] q3232_t;

	// APB address width: two 32-bit registers at byte addresses 0 and 4.
	localparam int unsigned APB_AW = 3;

	// Register indexes (byte address divided by four).
	localparam logic [0:0] REG_ACT_DIST = 1'b0;
	localparam logic [0:0] REG_STIFF    = 1'b1;

	localparam uq824_t  ACT_DIST_RST = 32'h0100_0000;
	localparam uq1616_t STIFF_RST    = 32'h0001_0000;

	// ln(2) as an unsigned Q0.32 fraction.
	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

	localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

endpackage

@@ hdl/lbc_if.sv @@
// ----------------------------------------------------------------------------
// lbc_if
// Request and result channels of the log-barrier contact kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbc_contact_if import lbc_pkg::*; ();
	logic   valid;
	logic   ready;
	vid_t   vertex_id;
	uq824_t distance;
	q824_t  offset_x;
	q824_t  offset_y;
	q824_t  offset_z;

	modport source (output valid, vertex_id, distance, offset_x, offset_y, offset_z,
		input ready);
	modport sink (input valid, vertex_id, distance, offset_x, offset_y, offset_z,
		output ready);
endinterface

interface lbc_result_if import lbc_pkg::*; ();
	logic   valid;
	logic   ready;
	vid_t   out_vertex_id;
	logic   contact_active;
	q3232_t energy_term;
	q3232_t gradient_x;
	q3232_t gradient_y;
	q3232_t gradient_z;
	q3232_t hessian_diagonal;
	logic   value_saturated;

	modport source (output valid, out_vertex_id, contact_active, energy_term, gradient_x,
		gradient_y, gradient_z, hessian_diagonal, value_saturated, input ready);
	modport sink (input valid, out_vertex_id, contact_active, energy_term, gradient_x,
		gradient_y, gradient_z, hessian_diagonal, value_saturated, output ready);
endinterface

@@ hdl/log_barrier_contact_kernel.sv @@
// ----------------------------------------------------------------------------
// log_barrier_contact_kernel
// Throughput: one request per cycle; the deepest unit is the 121-stage gradient divider.
// A stalled result freezes the whole pipeline in place; nothing is lost or repeated.
// Reset clears all valid bits and loads d_hat = 1.0 and stiffness = 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_barrier_contact_kernel import lbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	lbc_contact_if.sink       contact,
	lbc_result_if.source      result
);

	// Stage numbers in the comments below count the registers an operand has
	// passed since the request was accepted (stage 0 is the input port).

	// ---------------------------------------------------------------- config
	logic [31:0] act_dist_q;
	logic [31:0] stiff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_dist_q <= ACT_DIST_RST;
			stiff_q    <= STIFF_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_ACT_DIST: act_dist_q <= pwdata;
				REG_STIFF:    stiff_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ACT_DIST: prdata = act_dist_q;
			REG_STIFF:    prdata = stiff_q;
			default:      prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// ------------------------------------------------------- pipeline control
	// Every stage moves together; the output register decides whether it may.
	logic adv;
	logic res_valid_q;

	assign adv           = !res_valid_q || result.ready;
	assign contact.ready = adv;

	// ------------------------------------------------------------ stage 0
	logic [31:0] d0;
	logic [31:0] t0;
	logic        act0;

	assign d0   = contact.distance;
	assign t0   = act_dist_q - d0;
	assign act0 = (d0 != '0) && (d0 < act_dist_q);

	// Logarithms of d_hat and d, ready at stage 33.
	logic [36:0] la;
	logic [36:0] lb;

	lbc_log2 u_log_dh (.clk(clk), .en(adv), .x(act_dist_q), .lg(la));
	lbc_log2 u_log_d  (.clk(clk), .en(adv), .x(d0),         .lg(lb));

	// T = t * 2^32 / d, ready at stage 64.
	logic [63:0] tee;

	lbc_div #(.NW(64), .DW(32)) u_tee (
		.clk(clk), .en(adv), .num({t0, 32'b0}), .den(d0), .quo(tee)
	);

	// d^2, d_hat^2 and t^2 at stage 4.
	logic [63:0] dd;
	logic [63:0] dh2;
	logic [63:0] tt;

	lbc_mul #(.AW(32), .BW(32)) u_dd  (.clk(clk), .en(adv), .a(d0), .b(d0), .p(dd));
	lbc_mul #(.AW(32), .BW(32)) u_dh2 (.clk(clk), .en(adv), .a(act_dist_q), .b(act_dist_q),
		.p(dh2));
	lbc_mul #(.AW(32), .BW(32)) u_tt  (.clk(clk), .en(adv), .a(t0), .b(t0), .p(tt));

	// (d_hat / d)^2 as Q.32: a single divide by d^2 matches two divides by d.
	logic [95:0] r2;

	lbc_div #(.NW(96), .DW(64)) u_r2 (
		.clk(clk), .en(adv), .num({dh2, 32'b0}), .den(dd), .quo(r2)
	);

	// ------------------------------------------------------- stage 33 to 41
	// L = -ln(d / d_hat) as Q.32.
	logic [36:0] lgd;
	logic [68:0] ell_p;
	logic [36:0] ell;

	assign lgd = (la > lb) ? (la - lb) : '0;

	lbc_mul #(.AW(37), .BW(32)) u_ell (.clk(clk), .en(adv), .a(lgd), .b(LN2_Q32), .p(ell_p));
	assign ell = ell_p[68:32];

	logic [63:0] tt37;
	logic [31:0] t37;

	lbc_dly #(.W(64), .N(33)) u_dly_tt  (.clk(clk), .arst_n(arst_n), .en(adv), .din(tt),
		.dout(tt37));
	lbc_dly #(.W(32), .N(37)) u_dly_t37 (.clk(clk), .arst_n(arst_n), .en(adv), .din(t0),
		.dout(t37));

	// Barrier value b = t^2 * L / 2^48, then the energy k * b / 2^16.
	logic [100:0] b_p;
	logic [52:0]  bval;
	logic [84:0]  e_p;
	logic [68:0]  emag;
	logic [64:0]  ene45;
	logic [64:0]  ene197;

	lbc_mul #(.AW(37), .BW(64)) u_b (.clk(clk), .en(adv), .a(ell), .b(tt37), .p(b_p));
	assign bval = b_p[100:48];

	lbc_mul #(.AW(53), .BW(32)) u_e (.clk(clk), .en(adv), .a(bval), .b(stiff_q), .p(e_p));
	assign emag = e_p[84:16];

	always_comb begin
		ene45[64]   = |emag[68:63];
		ene45[63:0] = ene45[64] ? SAT_POS : emag[63:0];
	end

	lbc_dly #(.W(65), .N(152)) u_dly_ene (.clk(clk), .arst_n(arst_n), .en(adv), .din(ene45),
		.dout(ene197));

	// -------------------------------------------------------- stage 41 to 76
	// |b'| = 2 * (t * L / 2^24) + t * T / 2^24
	logic [68:0] ellt_p;
	logic [45:0] part1;
	logic [45:0] part1_68;
	logic [31:0] t64;
	logic [95:0] ttee_p;
	logic [71:0] part2;
	logic [72:0] bp;

	lbc_mul #(.AW(37), .BW(32)) u_ellt (.clk(clk), .en(adv), .a(ell), .b(t37), .p(ellt_p));
	assign part1 = {ellt_p[68:24], 1'b0};

	lbc_dly #(.W(46), .N(27)) u_dly_p1 (.clk(clk), .arst_n(arst_n), .en(adv), .din(part1),
		.dout(part1_68));
	lbc_dly #(.W(32), .N(27)) u_dly_t64 (.clk(clk), .arst_n(arst_n), .en(adv), .din(t37),
		.dout(t64));

	lbc_mul #(.AW(32), .BW(64)) u_ttee (.clk(clk), .en(adv), .a(t64), .b(tee), .p(ttee_p));
	assign part2 = ttee_p[95:24];
	assign bp    = 73'(part1_68) + 73'(part2);

	// Scaled slope k * |b'| / 2^16 at stage 72.
	logic [104:0] kb_p;
	logic [88:0]  kb;

	lbc_mul #(.AW(73), .BW(32)) u_kb (.clk(clk), .en(adv), .a(bp), .b(stiff_q), .p(kb_p));
	assign kb = kb_p[104:16];

	// Distance copies for the later divides.
	logic [31:0] d68;
	logic [31:0] d76;

	lbc_dly #(.W(32), .N(68)) u_dly_d68 (.clk(clk), .arst_n(arst_n), .en(adv), .din(d0),
		.dout(d68));
	lbc_dly #(.W(32), .N(8))  u_dly_d76 (.clk(clk), .arst_n(arst_n), .en(adv), .din(d68),
		.dout(d76));

	// |b'| / d for the Hessian, ready at stage 165.
	logic [96:0] bpd;

	lbc_div #(.NW(97), .DW(32)) u_bpd (
		.clk(clk), .en(adv), .num({bp, 24'b0}), .den(d68), .quo(bpd)
	);

	// -------------------------------------------------------------- gradient
	// Each axis: kb * |offset| / d, with the sign opposite to the offset.
	logic [95:0]  off72;
	logic [2:0]   cneg72;
	logic [2:0]   cneg197;
	logic [120:0] gq [3];

	lbc_dly #(.W(96), .N(72)) u_dly_off (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({contact.offset_z, contact.offset_y, contact.offset_x}), .dout(off72)
	);

	for (genvar i = 0; i < 3; i++) begin : g_axis
		logic [31:0]  c;
		logic [31:0]  mag;
		logic [120:0] gp;

		assign c         = off72[32*i +: 32];
		assign cneg72[i] = c[31];
		assign mag       = c[31] ? (~c + 32'd1) : c;

		lbc_mul #(.AW(89), .BW(32)) u_gmul (.clk(clk), .en(adv), .a(kb), .b(mag), .p(gp));

		lbc_div #(.NW(121), .DW(32)) u_gdiv (
			.clk(clk), .en(adv), .num(gp), .den(d76), .quo(gq[i])
		);
	end

	lbc_dly #(.W(3), .N(125)) u_dly_cneg (.clk(clk), .arst_n(arst_n), .en(adv),
		.din(cneg72), .dout(cneg197));

	// --------------------------------------------------------------- Hessian
	// b'' = 2L + 2T + ((d_hat / d)^2 - 1) at stage 100.
	logic [36:0] ell100;
	logic [63:0] tee100;
	logic [95:0] r2m;
	logic [97:0] bpp;
	logic [97:0] bpp165;

	lbc_dly #(.W(37), .N(63)) u_dly_ell (.clk(clk), .arst_n(arst_n), .en(adv), .din(ell),
		.dout(ell100));
	lbc_dly #(.W(64), .N(36)) u_dly_tee (.clk(clk), .arst_n(arst_n), .en(adv), .din(tee),
		.dout(tee100));

	assign r2m = r2 - 96'h1_0000_0000;
	assign bpp = 98'({ell100, 1'b0}) + 98'({tee100, 1'b0}) + 98'(r2m);

	lbc_dly #(.W(98), .N(65)) u_dly_bpp (.clk(clk), .arst_n(arst_n), .en(adv), .din(bpp),
		.dout(bpp165));

	// H = b'' + |b'| / d, capped at 2^79 before the stiffness scaling. The cap
	// is at or above the saturation point, so it never hides a clamp.
	logic [98:0]  hsum;
	logic [79:0]  hcap;
	logic [111:0] h_p;
	logic [95:0]  hmag;
	logic [64:0]  hes169;
	logic [64:0]  hes197;

	assign hsum = 99'(bpp165) + 99'(bpd);
	assign hcap = (hsum > (99'(1) << 79)) ? {1'b1, 79'b0} : hsum[79:0];

	lbc_mul #(.AW(80), .BW(32)) u_h (.clk(clk), .en(adv), .a(hcap), .b(stiff_q), .p(h_p));
	assign hmag = h_p[111:16];

	always_comb begin
		hes169[64]   = |hmag[95:63];
		hes169[63:0] = hes169[64] ? SAT_POS : hmag[63:0];
	end

	lbc_dly #(.W(65), .N(28)) u_dly_hes (.clk(clk), .arst_n(arst_n), .en(adv), .din(hes169),
		.dout(hes197));

	// ------------------------------------------------------ side information
	logic [20:0] side197;
	logic        vld197;

	lbc_dly #(.W(21), .N(197)) u_dly_side (.clk(clk), .arst_n(arst_n), .en(adv),
		.din({contact.vertex_id, act0}), .dout(side197));
	lbc_dly #(.W(1), .N(197)) u_dly_vld (.clk(clk), .arst_n(arst_n), .en(adv),
		.din(contact.valid), .dout(vld197));

	// ------------------------------------------------------- stage 197 merge
	// Returns {clamped, value} for one gradient axis.
	function automatic logic [64:0] grad_out(input logic [120:0] g, input logic cneg);
		logic neg;
		logic sat;
		logic [63:0] val;
		neg = !cneg && (g != '0);
		if (neg) begin
			sat = (|g[120:64]) || (g[63:0] > SAT_NEG);
			val = sat ? SAT_NEG : (~g[63:0] + 64'd1);
		end else begin
			sat = |g[120:63];
			val = sat ? SAT_POS : g[63:0];
		end
		return {sat, val};
	endfunction

	logic [64:0] gout [3];
	logic        act197;
	logic        any_sat;

	assign act197 = side197[0];

	always_comb begin
		for (int i = 0; i < 3; i++) gout[i] = grad_out(gq[i], cneg197[i]);
		any_sat = ene197[64] || hes197[64] || gout[0][64] || gout[1][64] || gout[2][64];
	end

	// ------------------------------------------------------- output register
	vid_t        res_vid_q;
	logic        res_act_q;
	logic [63:0] res_ene_q;
	logic [63:0] res_gx_q;
	logic [63:0] res_gy_q;
	logic [63:0] res_gz_q;
	logic [63:0] res_hes_q;
	logic        res_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= vld197;
		end
	end

	// Inactive contacts keep only the vertex id; everything else reads zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_vid_q <= side197[20:1];
			res_act_q <= act197;
			res_ene_q <= act197 ? ene197[63:0]  : '0;
			res_gx_q  <= act197 ? gout[0][63:0] : '0;
			res_gy_q  <= act197 ? gout[1][63:0] : '0;
			res_gz_q  <= act197 ? gout[2][63:0] : '0;
			res_hes_q <= act197 ? hes197[63:0]  : '0;
			res_sat_q <= act197 && any_sat;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.out_vertex_id    = res_vid_q;
	assign result.contact_active   = res_act_q;
	assign result.energy_term      = res_ene_q;
	assign result.gradient_x       = res_gx_q;
	assign result.gradient_y       = res_gy_q;
	assign result.gradient_z       = res_gz_q;
	assign result.hessian_diagonal = res_hes_q;
	assign result.value_saturated  = res_sat_q;

endmodule

@@ hdl/lbc_dly.sv @@
// ----------------------------------------------------------------------------
// lbc_dly
// Enable-gated shift line that keeps side data aligned with the arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[N-1];

endmodule

@@ hdl/lbc_mul.sv @@
// ----------------------------------------------------------------------------
// lbc_mul
// Pipelined unsigned multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);

	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int RW = 32 * NB + 32;
	localparam int PW = 32 * (NA + NB);

	logic [32*NA-1:0] a_s1;
	logic [32*NB-1:0] b_s1;
	logic [63:0]      pp_s2  [NA][NB];
	logic [RW-1:0]    row_s3 [NA];
	logic [PW-1:0]    p_s4;
	logic [RW-1:0]    row_sum [NA];
	logic [PW-1:0]    p_sum;

	// Each row collects the products of one limb of a; the rows are then summed.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_sum[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_sum[i] = row_sum[i] + (RW'(pp_s2[i][j]) << (32 * j));
			end
		end
		p_sum = '0;
		for (int i = 0; i < NA; i++) begin
			p_sum = p_sum + (PW'(row_s3[i]) << (32 * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= (32*NA)'(a);
			b_s1 <= (32*NB)'(b);
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= {32'b0, a_s1[32*i +: 32]} * {32'b0, b_s1[32*j +: 32]};
				end
			end
			row_s3 <= row_sum;
			p_s4   <= p_sum;
		end
	end

	assign p = p_s4[AW+BW-1:0];

endmodule

@@ hdl/lbc_div.sv @@
// ----------------------------------------------------------------------------
// lbc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	// The dividend shifts out at the top while quotient bits shift in below.
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [NW-1:0] nq_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign trial = {rem_in, nq_in[NW-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
				nq_s[k]  <= {nq_in[NW-2:0], ge};
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = nq_s[NW-1];

endmodule

@@ hdl/lbc_log2.sv @@
// ----------------------------------------------------------------------------
// lbc_log2
// Pipelined base-2 logarithm of a 32-bit value, result as Q5.32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_log2 (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] x,
	output logic [36:0] lg
);

	localparam int FB = 32;

	logic [4:0]  pos;
	logic [31:0] m_s [FB+1];
	logic [31:0] f_s [FB+1];
	logic [4:0]  p_s [FB+1];

	// Leading one gives the integer part; zero and one both give zero.
	always_comb begin
		pos = '0;
		for (int i = 1; i < 32; i++) begin
			if (x[i]) pos = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= x << (5'd31 - pos);
			f_s[0] <= '0;
			p_s[0] <= pos;
		end
	end

	// Each stage squares the Q1.31 mantissa and yields one fraction bit.
	for (genvar k = 0; k < FB; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] hi;

		assign sq = {32'b0, m_s[k]} * {32'b0, m_s[k]};
		assign hi = sq[63:31];

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1] <= hi[32] ? hi[32:1] : hi[31:0];
				f_s[k+1] <= {f_s[k][30:0], hi[32]};
				p_s[k+1] <= p_s[k];
			end
		end
	end

	assign lg = {p_s[FB], f_s[FB]};

endmodule

@@ bench/tb_log_barrier_contact_kernel.sv @@
// ----------------------------------------------------------------------------
// tb_log_barrier_contact_kernel
// Self-checking bench for the log-barrier contact kernel. Contacts stream in
// through a queue-fed driver; an independent fixed-point model predicts every
// result, and a monitor compares each returned result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_log_barrier_contact_kernel;
	import lbc_pkg::*;

	typedef struct {
		vid_t   vertex_id;
		uq824_t distance;
		q824_t  offset_x;
		q824_t  offset_y;
		q824_t  offset_z;
	} contact_t;

	typedef struct {
		vid_t        vertex_id;
		logic        active;
		logic [63:0] energy;
		logic [63:0] grad_x;
		logic [63:0] grad_y;
		logic [63:0] grad_z;
		logic [63:0] hessian;
		logic        saturated;
	} barrier_t;

	localparam int unsigned PIPE_DEPTH = 198;
	localparam int unsigned STALL_LEN  = 500;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	lbc_contact_if contact ();
	lbc_result_if  result ();

	log_barrier_contact_kernel dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.contact (contact),
		.result  (result)
	);

	// Copy of the two registers as the model sees them.
	uq824_t  model_dhat = ACT_DIST_RST;
	uq1616_t model_gain = STIFF_RST;

	contact_t pending_contacts[$];
	barrier_t expected_barriers[$];
	int       error_count = 0;
	int       active_seen = 0;
	int       saturated_seen = 0;
	int       results_seen = 0;
	bit       no_idle = 1'b0;
	int       hold_off_left = 0;
	int       hold_off_asked = 0;
	int       hold_off_served = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// log2 of a raw 32-bit value as Q.32: integer part from the leading one,
	// fraction bits from repeated squaring of the normalized mantissa.
	function automatic logic [63:0] log2_q32(logic [31:0] x);
		int          p;
		logic [63:0] m;
		logic [63:0] f;
		p = 31;
		while (p > 0 && !x[p]) p--;
		m = 64'(x) << (31 - p);
		f = '0;
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			f = f << 1;
			if (m >= 64'h1_0000_0000) begin
				f = f | 64'd1;
				m = m >> 1;
			end
		end
		return (64'(p) << 32) | f;
	endfunction

	// Clamp a magnitude with a sign into signed Q32.32.
	function automatic logic [63:0] clamp_q3232(logic [127:0] mag, bit neg, inout logic sat);
		if (neg) begin
			if (mag[127:64] != 0 || mag[63:0] > SAT_NEG) begin
				sat = 1'b1;
				return SAT_NEG;
			end
			return 64'd0 - mag[63:0];
		end
		if (mag[127:64] != 0 || mag[63:0] > SAT_POS) begin
			sat = 1'b1;
			return SAT_POS;
		end
		return mag[63:0];
	endfunction

	// Stiffness scaling; the cap at 2^79 keeps the product inside 128 bits.
	function automatic logic [127:0] apply_gain(logic [127:0] a, logic [31:0] k);
		logic [127:0] cap;
		cap = 128'd1 << 79;
		if (a > cap) a = cap;
		return (a * 128'(k)) >> 16;
	endfunction

	function automatic barrier_t barrier_terms(contact_t c);
		barrier_t     r;
		logic [63:0]  dh, k, d, t, la, lb, lgd, tee, tt, mag;
		logic [127:0] ell, b, bp, kb, r2, bpp, h, g;
		logic [31:0]  comp;
		logic         sat;
		bit           cneg;
		dh = 64'(model_dhat);
		k  = 64'(model_gain);
		d  = 64'(c.distance);
		r = '{c.vertex_id, 1'b0, '0, '0, '0, '0, '0, 1'b0};
		if (d == 0 || d >= dh) return r;
		r.active = 1'b1;
		sat = 1'b0;
		t   = dh - d;
		la  = log2_q32(dh[31:0]);
		lb  = log2_q32(d[31:0]);
		lgd = (la > lb) ? la - lb : 64'd0;
		ell = (128'(lgd) * 128'(LN2_Q32)) >> 32;
		tee = (t << 32) / d;
		tt  = t * t;
		b   = (ell * 128'(tt)) >> 48;
		bp  = (((ell * 128'(t)) >> 24) << 1) + ((128'(t) * 128'(tee)) >> 24);
		kb  = (bp * 128'(k)) >> 16;
		// Ratio (d_hat/d)^2 as Q.32 minus one.
		r2  = ((((128'(dh) * 128'(dh)) << 32) / 128'(d)) / 128'(d)) - 128'h1_0000_0000;
		bpp = (ell << 1) + (128'(tee) << 1) + r2;
		h   = bpp + ((bp << 24) / 128'(d));
		r.energy = clamp_q3232(apply_gain(b, k[31:0]), 1'b0, sat);
		for (int i = 0; i < 3; i++) begin
			comp = (i == 0) ? c.offset_x : (i == 1) ? c.offset_y : c.offset_z;
			cneg = comp[31];
			mag  = cneg ? (64'h1_0000_0000 - 64'(comp)) : 64'(comp);
			g    = (kb * 128'(mag)) / 128'(d);
			// The gradient pushes against the offset direction.
			case (i)
				0: r.grad_x = clamp_q3232(g, !cneg && g != 0, sat);
				1: r.grad_y = clamp_q3232(g, !cneg && g != 0, sat);
				default: r.grad_z = clamp_q3232(g, !cneg && g != 0, sat);
			endcase
		end
		r.hessian   = clamp_q3232(apply_gain(h, k[31:0]), 1'b0, sat);
		r.saturated = sat;
		return r;
	endfunction

	// Request driver: offers the next pending contact, idling at random except
	// in the no-idle stretch. A request once offered stays until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			contact.valid     <= 1'b0;
			contact.vertex_id <= '0;
			contact.distance  <= '0;
			contact.offset_x  <= '0;
			contact.offset_y  <= '0;
			contact.offset_z  <= '0;
		end else if (!contact.valid || contact.ready) begin
			if (pending_contacts.size() > 0 && (no_idle || $urandom_range(99) >= 19)) begin
				contact_t nxt;
				nxt = pending_contacts.pop_front();
				contact.valid     <= 1'b1;
				contact.vertex_id <= nxt.vertex_id;
				contact.distance  <= nxt.distance;
				contact.offset_x  <= nxt.offset_x;
				contact.offset_y  <= nxt.offset_y;
				contact.offset_z  <= nxt.offset_z;
			end else begin
				contact.valid <= 1'b0;
			end
		end
	end

	// Every accepted request gets its expected result from the model.
	always @(posedge clk) begin
		if (contact.valid && contact.ready) begin
			contact_t acc;
			acc.vertex_id = contact.vertex_id;
			acc.distance  = contact.distance;
			acc.offset_x  = contact.offset_x;
			acc.offset_y  = contact.offset_y;
			acc.offset_z  = contact.offset_z;
			expected_barriers.push_back(barrier_terms(acc));
		end
	end

	// Result back-pressure: random idling, plus a long hold-off on request so
	// the pipeline fills and stalls its input.
	always @(posedge clk) begin
		if (hold_off_left > 0) begin
			hold_off_left <= hold_off_left - 1;
			result.ready  <= 1'b0;
		end else if (hold_off_served != hold_off_asked) begin
			hold_off_served <= hold_off_served + 1;
			hold_off_left   <= STALL_LEN - 1;
			result.ready    <= 1'b0;
		end else begin
			result.ready <= arst_n && (no_idle || $urandom_range(99) >= 19);
		end
	end

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %h, got %h", name, exp, act);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (result.valid && result.ready) begin
			barrier_t exp;
			results_seen++;
			if (expected_barriers.size() == 0) begin
				$error("result for vertex %h arrived with nothing expected", result.out_vertex_id);
				error_count++;
			end else begin
				exp = expected_barriers.pop_front();
				check_field("out_vertex_id", 64'(exp.vertex_id), 64'(result.out_vertex_id));
				check_field("contact_active", 64'(exp.active), 64'(result.contact_active));
				check_field("energy_term", exp.energy, result.energy_term);
				check_field("gradient_x", exp.grad_x, result.gradient_x);
				check_field("gradient_y", exp.grad_y, result.gradient_y);
				check_field("gradient_z", exp.grad_z, result.gradient_z);
				check_field("hessian_diagonal", exp.hessian, result.hessian_diagonal);
				check_field("value_saturated", 64'(exp.saturated), 64'(result.value_saturated));
				if (exp.active) active_seen++;
				if (exp.saturated) saturated_seen++;
			end
		end
	end

	// Register write over the APB port: setup cycle, then access cycle.
	task automatic write_register(logic [0:0] index, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_ACT_DIST) model_dhat = value;
		else model_gain = value;
	endtask

	function automatic q824_t pick_offset();
		case ($urandom_range(5))
			0: return q824_t'(32'h8000_0000);
			1: return q824_t'(32'h7FFF_FFFF);
			2: return q824_t'($urandom_range(32'h0200_0000)) - q824_t'(32'h0100_0000);
			3: return '0;
			default: return q824_t'($urandom);
		endcase
	endfunction

	// Random contact against the current d_hat: mostly inside the barrier
	// band, with some close to zero distance, outside the band and zero.
	function automatic contact_t random_contact();
		contact_t c;
		int unsigned sel;
		c.vertex_id = vid_t'($urandom);
		c.offset_x  = pick_offset();
		c.offset_y  = pick_offset();
		c.offset_z  = pick_offset();
		sel = $urandom_range(99);
		if (sel < 60 && model_dhat > 1)
			c.distance = $urandom_range(model_dhat - 1, 1);
		else if (sel < 72 && model_dhat > 1)
			c.distance = $urandom_range((model_dhat > 256) ? 255 : model_dhat - 1, 1);
		else if (sel < 80 && model_dhat > 1)
			c.distance = model_dhat - $urandom_range((model_dhat > 16) ? 15 : model_dhat - 1, 1);
		else if (sel < 90)
			c.distance = $urandom_range(32'hFFFF_FFFF, model_dhat);
		else if (sel < 94)
			c.distance = '0;
		else
			c.distance = $urandom;
		return c;
	endfunction

	task automatic queue_contact(vid_t v, uq824_t d, q824_t x, q824_t y, q824_t z);
		pending_contacts.push_back('{v, d, x, y, z});
	endtask

	task automatic run_random(int count);
		repeat (count) pending_contacts.push_back(random_contact());
	endtask

	// Waits until every queued request has been sent and its result has returned.
	task automatic drain();
		while (pending_contacts.size() > 0 || contact.valid || expected_barriers.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed contacts at reset settings (d_hat = 1.0, stiffness = 1.0):
		// zero distance, the smallest distance, the band edges, the largest
		// distance, and extreme offsets of each sign.
		queue_contact(20'h00000, 32'h0000_0000, 32'h0100_0000, 32'h0, 32'h0);
		queue_contact(20'hFFFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_contact(20'h00001, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h8000_0000);
		queue_contact(20'h12345, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFF00_0001, 32'h0);
		queue_contact(20'h54321, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
		queue_contact(20'hABCDE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_contact(20'h0F0F0, 32'h0080_0000, 32'h0080_0000, 32'h0, 32'h0);
		queue_contact(20'hF0F0F, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_1000, 32'h0);
		queue_contact(20'h33333, 32'h0010_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_contact(20'h77777, 32'h00FF_FFF0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
		run_random(237);
		drain();

		// Widest band and highest stiffness; the result side holds off long
		// enough for the pipeline to back up into the request side.
		write_register(REG_ACT_DIST, 32'hFFFF_FFFF);
		write_register(REG_STIFF, 32'hFFFF_FFFF);
		queue_contact(20'h00002, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		queue_contact(20'h00003, 32'hFFFF_FFFE, 32'h0100_0000, 32'h0, 32'hFF00_0000);
		queue_contact(20'h00004, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0, 32'h0);
		run_random(150);
		@(negedge clk);
		hold_off_asked++;
		drain();

		// Zero stiffness: active contacts with all values zero.
		write_register(REG_ACT_DIST, 32'h0800_0000);
		write_register(REG_STIFF, 32'h0000_0000);
		run_random(100);
		drain();

		// Smallest band: no distance can fall inside it.
		write_register(REG_ACT_DIST, 32'h0000_0001);
		write_register(REG_STIFF, STIFF_RST);
		run_random(60);
		drain();

		// Tight band with a tiny gain, run without any idling on either side.
		write_register(REG_ACT_DIST, 32'h0000_1000);
		write_register(REG_STIFF, 32'h0000_0001);
		no_idle = 1'b1;
		run_random(150);
		drain();
		no_idle = 1'b0;

		// Random settings, two rounds.
		repeat (2) begin
			write_register(REG_ACT_DIST, $urandom_range(32'hFFFF_FFFF, 1));
			write_register(REG_STIFF, $urandom);
			run_random(90);
			drain();
		end

		// Back to the reset values for a last stretch.
		write_register(REG_ACT_DIST, ACT_DIST_RST);
		write_register(REG_STIFF, STIFF_RST);
		run_random(60);
		drain();

		repeat (PIPE_DEPTH + 50) @(posedge clk);
		$display("Checked %0d contacts (%0d inside the band, %0d clamped) over eight settings.",
			results_seen, active_seen, saturated_seen);
		if (error_count == 0 && expected_barriers.size() == 0) begin
			$display("PASS log_barrier_contact_kernel");
		end else begin
			$display("FAIL log_barrier_contact_kernel");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL log_barrier_contact_kernel");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/lbc_pkg.sv
hdl/lbc_if.sv
hdl/lbc_dly.sv
hdl/lbc_mul.sv
hdl/lbc_div.sv
hdl/lbc_log2.sv
hdl/log_barrier_contact_kernel.sv
bench/tb_log_barrier_contact_kernel.sv
